FILE: hdl/stok_pkg.sv
// Shared types, constants and helper functions of the source tokenizer.
package stok_pkg;

  // Sizes of the token fields
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int OFFSET_BITS   = 24;
  localparam int POS_W         = 16;
  localparam int KEY_CHARS     = 6;
  localparam int KEY_W         = KEY_CHARS * 8;
  localparam int NUM_KW        = 13;

  // Result queue sizing
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Byte codes of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    K_END     = 4'd0,
    K_IDENT   = 4'd1,
    K_IF      = 4'd2,
    K_ELSE    = 4'd3,
    K_LIT     = 4'd4,
    K_NUM     = 4'd5,
    K_TYPE    = 4'd6,
    K_EQ      = 4'd7,
    K_SEMI    = 4'd8,
    K_LBRACE  = 4'd9,
    K_RBRACE  = 4'd10,
    K_LPAREN  = 4'd11,
    K_RPAREN  = 4'd12,
    K_RETURN  = 4'd13,
    K_BAD     = 4'd14,
    K_UNTERM  = 4'd15
  } kind_t;

  // One token as it leaves the block
  typedef struct packed {
    kind_t                  kind;
    logic [POS_W-1:0]       line;
    logic [POS_W-1:0]       col;
    logic [OFFSET_BITS-1:0] offset;
    logic [LEN_W-1:0]       len;
    logic                   last;
  } tok_t;

  // Up to two tokens produced by one source byte
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  typedef struct packed {
    logic [KEY_W-1:0] text;
    logic [3:0]       nchar;
    kind_t            kind;
  } kw_t;

  localparam kw_t KW_TABLE [NUM_KW] = '{
    '{KEY_W'("if"),     4'd2, K_IF},
    '{KEY_W'("else"),   4'd4, K_ELSE},
    '{KEY_W'("u8"),     4'd2, K_TYPE},
    '{KEY_W'("u16"),    4'd3, K_TYPE},
    '{KEY_W'("u32"),    4'd3, K_TYPE},
    '{KEY_W'("u64"),    4'd3, K_TYPE},
    '{KEY_W'("i8"),     4'd2, K_TYPE},
    '{KEY_W'("i16"),    4'd3, K_TYPE},
    '{KEY_W'("i32"),    4'd3, K_TYPE},
    '{KEY_W'("i64"),    4'd3, K_TYPE},
    '{KEY_W'("v0"),     4'd2, K_TYPE},
    '{KEY_W'("str"),    4'd3, K_TYPE},
    '{KEY_W'("return"), 4'd6, K_RETURN}
  };

  function automatic logic is_alpha(logic [7:0] ch);
    return (ch inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return (ch inside {[8'h30:8'h39]});
  endfunction

  // Match a captured word against the keyword set; long words stay identifiers
  function automatic kind_t word_kind(logic [KEY_W-1:0] cap, logic [LEN_W-1:0] len);
    kind_t res;
    res = K_IDENT;
    if (len <= LEN_W'(KEY_CHARS)) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (KW_TABLE[i].text == cap && len == LEN_W'(KW_TABLE[i].nchar)) begin
          res = KW_TABLE[i].kind;
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: hdl/stok_scan.sv
// Input register, scanner state and per-byte token generation.
module stok_scan import stok_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        room,
  output push_t       push
);

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_IDENT = 2'd1,
    M_NUM   = 2'd2,
    M_LIT   = 2'd3
  } mode_t;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

  logic                   in_valid_r;
  logic [7:0]             ch_r;
  mode_t                  mode_r, mode_nxt;
  logic [POS_W-1:0]       cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [OFFSET_BITS-1:0] cur_off_r, cur_off_nxt;
  logic [POS_W-1:0]       st_line_r, st_line_nxt, st_col_r, st_col_nxt;
  logic [OFFSET_BITS-1:0] st_off_r, st_off_nxt;
  logic [LEN_W-1:0]       run_len_r, run_len_nxt;
  logic [KEY_W-1:0]       cap_r, cap_nxt;

  logic                   fire;
  logic [POS_W-1:0]       adv_line, adv_col;
  logic [OFFSET_BITS-1:0] adv_off;
  logic [LEN_W-1:0]       len_inc;
  logic [KEY_W-1:0]       cap_ext;
  logic                   close, to_idle, emit_i;
  kind_t                  close_kind, emit_kind;
  logic [LEN_W-1:0]       close_len;
  tok_t                   close_tok, idle_tok;

  assign fire     = in_valid_r && room;
  assign in_ready = !in_valid_r || room;

  // Position after this byte
  always_comb begin
    adv_off  = cur_off_r + OFFSET_BITS'(1);
    adv_line = cur_line_r;
    adv_col  = cur_col_r;
    if (ch_r == CH_LF) begin
      adv_col = POS_ONE;
      if (cur_line_r != POS_MAX) adv_line = cur_line_r + POS_ONE;
    end else if (ch_r == CH_CR) begin
      adv_col = POS_ONE;
    end else if (cur_col_r != POS_MAX) begin
      adv_col = cur_col_r + POS_ONE;
    end
  end

  assign len_inc = (run_len_r == LEN_MAX) ? run_len_r : run_len_r + LEN_W'(1);
  assign cap_ext = (run_len_r < LEN_W'(KEY_CHARS)) ? {cap_r[KEY_W-9:0], ch_r} : cap_r;

  // Extend or close an open token, or treat the byte as between tokens
  always_comb begin
    mode_nxt     = mode_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    cur_off_nxt  = cur_off_r;
    st_line_nxt  = st_line_r;
    st_col_nxt   = st_col_r;
    st_off_nxt   = st_off_r;
    run_len_nxt  = run_len_r;
    cap_nxt      = cap_r;
    close        = 1'b0;
    close_kind   = K_IDENT;
    close_len    = run_len_r;
    to_idle      = 1'b0;
    emit_i       = 1'b0;
    emit_kind    = K_BAD;

    case (mode_r)
      M_IDENT: begin
        if (is_alpha(ch_r) || is_digit(ch_r)) begin
          cap_nxt      = cap_ext;
          run_len_nxt  = len_inc;
          cur_line_nxt = adv_line;
          cur_col_nxt  = adv_col;
          cur_off_nxt  = adv_off;
        end else begin
          close      = 1'b1;
          close_kind = word_kind(cap_r, run_len_r);
          to_idle    = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(ch_r)) begin
          run_len_nxt  = len_inc;
          cur_line_nxt = adv_line;
          cur_col_nxt  = adv_col;
          cur_off_nxt  = adv_off;
        end else begin
          close      = 1'b1;
          close_kind = K_NUM;
          to_idle    = 1'b1;
        end
      end
      M_LIT: begin
        if (ch_r == CH_QUOTE) begin
          close        = 1'b1;
          close_kind   = K_LIT;
          close_len    = len_inc;
          run_len_nxt  = len_inc;
          mode_nxt     = M_IDLE;
          cur_line_nxt = adv_line;
          cur_col_nxt  = adv_col;
          cur_off_nxt  = adv_off;
        end else if (ch_r == CH_NUL || ch_r == CH_LF || ch_r == CH_CR) begin
          close      = 1'b1;
          close_kind = K_UNTERM;
          to_idle    = 1'b1;
        end else begin
          run_len_nxt  = len_inc;
          cur_line_nxt = adv_line;
          cur_col_nxt  = adv_col;
          cur_off_nxt  = adv_off;
        end
      end
      default: to_idle = 1'b1;
    endcase

    if (to_idle) begin
      mode_nxt = M_IDLE;
      if (ch_r == CH_NUL) begin
        // End of input: report, then fall back to the reset state
        emit_i       = 1'b1;
        emit_kind    = K_END;
        cur_line_nxt = POS_ONE;
        cur_col_nxt  = POS_ONE;
        cur_off_nxt  = '0;
        st_line_nxt  = POS_ONE;
        st_col_nxt   = POS_ONE;
        st_off_nxt   = '0;
        run_len_nxt  = '0;
        cap_nxt      = '0;
      end else begin
        cur_line_nxt = adv_line;
        cur_col_nxt  = adv_col;
        cur_off_nxt  = adv_off;
        if (!(ch_r inside {CH_SP, CH_TAB, CH_LF, CH_CR})) begin
          st_line_nxt = cur_line_r;
          st_col_nxt  = cur_col_r;
          st_off_nxt  = cur_off_r;
          run_len_nxt = LEN_W'(1);
          if (is_alpha(ch_r)) begin
            mode_nxt = M_IDENT;
            cap_nxt  = KEY_W'(ch_r);
          end else if (is_digit(ch_r)) begin
            mode_nxt = M_NUM;
          end else if (ch_r == CH_QUOTE) begin
            mode_nxt = M_LIT;
          end else begin
            emit_i = 1'b1;
            case (ch_r)
              CH_EQ:     emit_kind = K_EQ;
              CH_SEMI:   emit_kind = K_SEMI;
              CH_LBRACE: emit_kind = K_LBRACE;
              CH_RBRACE: emit_kind = K_RBRACE;
              CH_LPAREN: emit_kind = K_LPAREN;
              CH_RPAREN: emit_kind = K_RPAREN;
              default:   emit_kind = K_BAD;
            endcase
          end
        end
      end
    end
  end

  // Assemble the beats for the result queue
  always_comb begin
    close_tok.kind   = close_kind;
    close_tok.line   = st_line_r;
    close_tok.col    = st_col_r;
    close_tok.offset = st_off_r;
    close_tok.len    = close_len;
    close_tok.last   = !emit_i;

    idle_tok.kind    = emit_kind;
    idle_tok.line    = cur_line_r;
    idle_tok.col     = cur_col_r;
    idle_tok.offset  = cur_off_r;
    idle_tok.len     = (emit_kind == K_END) ? '0 : LEN_W'(1);
    idle_tok.last    = 1'b1;

    push.t0 = close ? close_tok : idle_tok;
    push.t1 = idle_tok;
    push.n  = fire ? (2'(close) + 2'(emit_i)) : 2'd0;
  end

  // Hold the incoming byte until the queue has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) ch_r <= in_ch;
  end

  // Advance scanner state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      cur_line_r <= POS_ONE;
      cur_col_r  <= POS_ONE;
      cur_off_r  <= '0;
      st_line_r  <= POS_ONE;
      st_col_r   <= POS_ONE;
      st_off_r   <= '0;
      run_len_r  <= '0;
      cap_r      <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_off_r  <= cur_off_nxt;
      st_line_r  <= st_line_nxt;
      st_col_r   <= st_col_nxt;
      st_off_r   <= st_off_nxt;
      run_len_r  <= run_len_nxt;
      cap_r      <= cap_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ch_r == CH_NUL) |=> (mode_r == M_IDLE && cur_line_r == POS_ONE
                                  && cur_off_r == '0))
    else $error("end of input did not return scanner to start state");
  a_two_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (close && emit_i && mode_r != M_IDLE))
    else $error("two beats from one byte without a token closing");
  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |-> (push.n == 2'd0))
    else $error("beat pushed without a byte being processed");
  a_token_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != M_IDLE) |-> (run_len_r != '0))
    else $error("open token with zero length");
`endif

endmodule

FILE: hdl/stok_outq.sv
// Small result queue: up to two beats in per cycle, one out if ready.
module stok_outq import stok_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output tok_t        out_tok
);

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_tok   = mem_r[rd_ptr_r];
  assign room      = (count_r <= QCNT_W'(QDEPTH - 2));

  // Store incoming beats
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.t0;
    if (push.n == 2'd2) mem_r[wr_ptr_r + QPTR_W'(1)] <= push.t1;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.n);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r  <= count_r + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room)
    else $error("beats pushed into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue fill level out of range");
  a_push_legal: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd3)
    else $error("illegal beat count");
`endif

endmodule

FILE: hdl/source_tokenizer.sv
// Top level of the streaming source tokenizer.
//
//   channel   direction  handshake                  payload
//   in_       in         in_valid / in_ready        in_ch
//   out_      out        out_valid / out_ready      out_kind, out_tok_line, out_tok_col,
//                                                   out_tok_offset, out_tok_len, out_last
//
// One source byte per cycle is taken while the result queue has room; the scanner
// step sits between the input register and a four-beat result queue, into which
// its beats are registered. A byte that closes a token and is itself a one-byte
// token or the end of input gives two beats, so the sustained rate is limited by
// the one-beat-per-cycle drain of the result queue. rst_n is synchronous; it
// clears the scanner to line 1, column 1, offset 0. in_ready depends only on
// registered state, not on out_ready.
module source_tokenizer import stok_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_ch,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_kind,
  output logic [POS_W-1:0]       out_tok_line,
  output logic [POS_W-1:0]       out_tok_col,
  output logic [OFFSET_BITS-1:0] out_tok_offset,
  output logic [LEN_W-1:0]       out_tok_len,
  output logic                   out_last
);

  push_t push;
  logic  room;
  tok_t  out_tok;

  stok_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .room     (room),
    .push     (push)
  );

  stok_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  // Split the queued beat onto the result ports
  assign out_kind       = out_tok.kind;
  assign out_tok_line   = out_tok.line;
  assign out_tok_col    = out_tok.col;
  assign out_tok_offset = out_tok.offset;
  assign out_tok_len    = out_tok.len;
  assign out_last       = out_tok.last;

endmodule

FILE: test/token_checker.sv
// Token checker: follows the source byte stream, predicts each token and compares beats.
module token_checker import stok_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_ch,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [3:0]             out_kind,
  input  logic [POS_W-1:0]       out_tok_line,
  input  logic [POS_W-1:0]       out_tok_col,
  input  logic [OFFSET_BITS-1:0] out_tok_offset,
  input  logic [LEN_W-1:0]       out_tok_len,
  input  logic                   out_last,
  output int                     errors,
  output int                     waiting,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_LIT} scan_t;

  // Scanner state as the block should hold it
  scan_t                  mode;
  logic [POS_W-1:0]       line_now, col_now, line_at, col_at;
  logic [OFFSET_BITS-1:0] off_now, off_at;
  int unsigned            run_len;
  logic [KEY_W-1:0]       word_cap;

  // Tokens caused by the current byte, and tokens still owed by the block
  tok_t burst [2];
  int   n_burst;
  tok_t pending_tokens [$];
  tok_t want;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Words of more than KEY_CHARS bytes never match; letters and digits are never zero,
  // so the captured value alone fixes the length of a short word
  function automatic kind_t keyword_of(logic [KEY_W-1:0] cap, int unsigned len);
    kind_t k;
    k = K_IDENT;
    if (len <= KEY_CHARS) begin
      case (cap)
        KEY_W'("if"):     k = K_IF;
        KEY_W'("else"):   k = K_ELSE;
        KEY_W'("return"): k = K_RETURN;
        KEY_W'("u8"), KEY_W'("u16"), KEY_W'("u32"), KEY_W'("u64"),
        KEY_W'("i8"), KEY_W'("i16"), KEY_W'("i32"), KEY_W'("i64"),
        KEY_W'("v0"), KEY_W'("str"): k = K_TYPE;
        default: k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  task automatic clear_scan();
    mode     = SCAN_IDLE;
    line_now = POS_W'(1);
    col_now  = POS_W'(1);
    off_now  = '0;
    line_at  = POS_W'(1);
    col_at   = POS_W'(1);
    off_at   = '0;
    run_len  = 0;
    word_cap = '0;
  endtask

  // Advance the position past one byte; line and column stick at their maximum
  task automatic step_pos(input logic [7:0] c);
    off_now = off_now + OFFSET_BITS'(1);
    if (c == CH_LF) begin
      col_now = POS_W'(1);
      if (line_now != '1) line_now = line_now + POS_W'(1);
    end else if (c == CH_CR) begin
      col_now = POS_W'(1);
    end else if (col_now != '1) begin
      col_now = col_now + POS_W'(1);
    end
  endtask

  task automatic mark_start();
    line_at = line_now;
    col_at  = col_now;
    off_at  = off_now;
  endtask

  task automatic lengthen();
    if (run_len <= MAX_TOKEN_LEN) run_len++;
  endtask

  task automatic add_token(input kind_t k, input int unsigned len);
    tok_t t;
    t.kind   = k;
    t.line   = line_at;
    t.col    = col_at;
    t.offset = off_at;
    t.len    = (len > MAX_TOKEN_LEN) ? LEN_W'(MAX_TOKEN_LEN) : LEN_W'(len);
    t.last   = 1'b0;
    burst[n_burst] = t;
    n_burst++;
  endtask

  // Handle a byte with no token open
  task automatic idle_scan(input logic [7:0] c);
    kind_t k;
    if (c == CH_NUL) begin
      mark_start();
      add_token(K_END, 0);
      clear_scan();
    end else if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR) begin
      step_pos(c);
    end else begin
      mark_start();
      if (is_letter(c)) begin
        mode     = SCAN_WORD;
        run_len  = 1;
        word_cap = KEY_W'(c);
      end else if (is_numeral(c)) begin
        mode    = SCAN_NUM;
        run_len = 1;
      end else if (c == CH_QUOTE) begin
        mode    = SCAN_LIT;
        run_len = 1;
      end else begin
        case (c)
          CH_EQ:     k = K_EQ;
          CH_SEMI:   k = K_SEMI;
          CH_LBRACE: k = K_LBRACE;
          CH_RBRACE: k = K_RBRACE;
          CH_LPAREN: k = K_LPAREN;
          CH_RPAREN: k = K_RPAREN;
          default:   k = K_BAD;
        endcase
        add_token(k, 1);
      end
      step_pos(c);
    end
  endtask

  // Work out the tokens that one accepted byte causes and queue them
  task automatic scan_byte(input logic [7:0] c);
    n_burst = 0;
    case (mode)
      SCAN_WORD: begin
        if (is_letter(c) || is_numeral(c)) begin
          if (run_len < KEY_CHARS) word_cap = {word_cap[KEY_W-9:0], c};
          lengthen();
          step_pos(c);
        end else begin
          add_token(keyword_of(word_cap, run_len), run_len);
          mode = SCAN_IDLE;
          idle_scan(c);
        end
      end
      SCAN_NUM: begin
        if (is_numeral(c)) begin
          lengthen();
          step_pos(c);
        end else begin
          add_token(K_NUM, run_len);
          mode = SCAN_IDLE;
          idle_scan(c);
        end
      end
      SCAN_LIT: begin
        if (c == CH_QUOTE) begin
          lengthen();
          step_pos(c);
          add_token(K_LIT, run_len);
          mode = SCAN_IDLE;
        end else if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
          // a line end or end of input breaks the literal, then is handled afresh
          add_token(K_UNTERM, run_len);
          mode = SCAN_IDLE;
          idle_scan(c);
        end else begin
          lengthen();
          step_pos(c);
        end
      end
      default: idle_scan(c);
    endcase
    if (n_burst > 0) burst[n_burst-1].last = 1'b1;
    for (int i = 0; i < n_burst; i++) pending_tokens.insert(pending_tokens.size(), burst[i]);
  endtask

  task automatic compare(input string name, input longint unsigned exp_v,
                         input longint unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: token %0d %s mismatch: expected %0d, got %0d",
               $time, checked, name, exp_v, got_v);
    end
  endtask

  // Check the result beat first, then predict from the input beat of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      pending_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_tokens.size() == 0) begin
          errors++;
          $display("%0t: unexpected token: expected none, got kind %0d line %0d col %0d",
                   $time, out_kind, out_tok_line, out_tok_col);
        end else begin
          want = pending_tokens.pop_front();
          compare("kind", want.kind, out_kind);
          compare("line", want.line, out_tok_line);
          compare("col", want.col, out_tok_col);
          compare("offset", want.offset, out_tok_offset);
          compare("len", want.len, out_tok_len);
          compare("last", want.last, out_last);
          checked++;
        end
      end
      if (in_valid && in_ready) scan_byte(in_ch);
    end
    waiting = pending_tokens.size();
  end

endmodule

FILE: test/testbench.sv
// Top of the source tokenizer testbench: clock, reset, byte stimulus and verdict.
module testbench import stok_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 100000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_ch;
  logic                   out_valid;
  logic                   out_ready;
  logic [3:0]             out_kind;
  logic [POS_W-1:0]       out_tok_line;
  logic [POS_W-1:0]       out_tok_col;
  logic [OFFSET_BITS-1:0] out_tok_offset;
  logic [LEN_W-1:0]       out_tok_len;
  logic                   out_last;

  int   errors, waiting, checked;
  int   send_pct, stall_pct;
  int   sent_bytes;
  logic hold_req;

  string keywords [14] = '{"if", "else", "u8", "u16", "u32", "u64", "i8", "i16",
                           "i32", "i64", "v0", "str", "return", "elsif"};

  source_tokenizer dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_ch,
    .out_valid, .out_ready, .out_kind, .out_tok_line, .out_tok_col,
    .out_tok_offset, .out_tok_len, .out_last
  );

  token_checker watch (
    .clk, .rst_n, .in_valid, .in_ready, .in_ch,
    .out_valid, .out_ready, .out_kind, .out_tok_line, .out_tok_col,
    .out_tok_offset, .out_tok_len, .out_last,
    .errors, .waiting, .checked
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, with a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one byte after a random gap and hold it until the beat is taken
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_pct) gap++;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_repeat(input logic [7:0] c, input int n);
    repeat (n) send_byte(c);
  endtask

  // Drop valid and hold off until every owed token has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                             : 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic logic [7:0] rand_word_char();
    return $urandom_range(3) == 0 ? 8'($urandom_range(8'h30, 8'h39)) : rand_letter();
  endfunction

  // Send one well-formed fragment, now and then a broken one or noise
  task automatic random_token();
    int          r, n;
    logic [7:0]  c;
    logic [7:0]  punct [6];
    logic [7:0]  blank [4];
    punct = '{CH_EQ, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN};
    blank = '{CH_SP, CH_TAB, CH_LF, CH_CR};
    r = $urandom_range(99);
    if (r < 20) begin
      send_text(keywords[$urandom_range(13)]);
      if ($urandom_range(4) == 0) send_byte(rand_word_char());
    end else if (r < 35) begin
      send_byte(rand_letter());
      repeat ($urandom_range(9)) send_byte(rand_word_char());
    end else if (r < 47) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h30, 8'h39)));
    end else if (r < 57) begin
      send_byte(CH_QUOTE);
      n = $urandom_range(8);
      repeat (n) begin
        c = 8'($urandom_range(1, 255));
        if (c == CH_QUOTE || c == CH_LF || c == CH_CR) c = 8'h78;
        send_byte(c);
      end
      // mostly close the literal, otherwise break it
      if ($urandom_range(99) < 85) send_byte(CH_QUOTE);
      else send_byte($urandom_range(2) == 0 ? CH_NUL : ($urandom_range(1) ? CH_LF : CH_CR));
    end else if (r < 75) begin
      send_byte(punct[$urandom_range(5)]);
    end else if (r < 93) begin
      repeat ($urandom_range(1, 3)) send_byte(blank[$urandom_range(3)]);
    end else if (r < 98) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(CH_NUL);
    end
    if ($urandom_range(1)) send_byte(blank[$urandom_range(3)]);
  endtask

  task automatic random_stream(input int n);
    int stop_at;
    stop_at = sent_bytes + n;
    while (sent_bytes < stop_at) random_token();
    send_byte(CH_NUL);
  endtask

  initial begin
    int send_mix  [4];
    int stall_mix [4];
    int guard;
    send_mix   = '{0, 75, 0, 35};
    stall_mix  = '{0, 0, 75, 35};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_ch      = '0;
    hold_req   = 1'b0;
    send_pct   = 0;
    stall_pct  = 0;
    sent_bytes = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: keywords, punctuation, number, broken literal, bad byte, end
    send_text("if(x)else{return 7;}");
    send_text("\"b\n");
    send_byte(8'hFF);
    send_byte(CH_NUL);
    wait_drained();

    // Long tokens: lengths stick at the maximum; a literal broken by end of input
    send_repeat(8'h61, 260);
    send_byte(CH_SP);
    send_byte(CH_QUOTE);
    send_repeat(8'h7A, 260);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_repeat(8'h71, 5);
    send_byte(CH_NUL);
    wait_drained();

    // Receiver holds off while the sender keeps pushing, then pause until drained
    hold_req = 1'b1;
    send_repeat(CH_SEMI, 40);
    send_byte(CH_NUL);
    wait_drained();

    // Random streams under each idling mix
    for (int m = 0; m < 4; m++) begin
      send_pct  = send_mix[m];
      stall_pct = stall_mix[m];
      random_stream(100);
      wait_drained();
    end

    // Let the block settle, bounded
    in_valid <= 1'b0;
    guard = 0;
    while (waiting != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);

    $display("Sent %0d source bytes and checked %0d tokens over four idling mixes,",
             sent_bytes, checked);
    $display("including over-long words and literals and a long receiver hold-off.");
    if (errors == 0 && waiting == 0) begin
      $display("[source_tokenizer] OK");
    end else begin
      $display("[source_tokenizer] ERROR");
    end
    $finish;
  end

  // Give up well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("[source_tokenizer] ERROR");
    $finish;
  end

endmodule

FILE: source_tokenizer.f
hdl/stok_pkg.sv
hdl/stok_scan.sv
hdl/stok_outq.sv
hdl/source_tokenizer.sv
test/token_checker.sv
test/testbench.sv
